### src/rtnp_pkg.sv
`default_nettype none

package rtnp_pkg;

   localparam int SOURCE_WIDTH    = 16;
   localparam int PIXEL_WIDTH     = 32;
   localparam int MASK_WIDTH      = 32;
   localparam int SHIFT_WIDTH     = 5;
   localparam int PROD_WIDTH      = SOURCE_WIDTH + MASK_WIDTH;
   localparam int DIV_STEP_BITS   = 4;
   localparam int DIV_STAGES      = MASK_WIDTH / DIV_STEP_BITS;
   // multiply, divider steps, select/shift, output OR
   localparam int STAGES          = DIV_STAGES + 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [MASK_WIDTH-1:0] RED_MASK_RESET   = 32'h00FF_0000;
   localparam logic [MASK_WIDTH-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
   localparam logic [MASK_WIDTH-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;
   localparam logic [SOURCE_WIDTH-1:0] SOURCE_MAX_RESET = 16'd255;

   localparam logic [MASK_WIDTH-1:0] PIXEL_KEEP =
      (PIXEL_WIDTH >= MASK_WIDTH) ? {MASK_WIDTH{1'b1}}
                                  : MASK_WIDTH'((64'd1 << PIXEL_WIDTH) - 64'd1);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RED_MASK  = 3'd0,
      CSR_GREEN_MASK = 3'd1,
      CSR_BLUE_MASK = 3'd2,
      CSR_RED_MAX   = 3'd3,
      CSR_GREEN_MAX = 3'd4,
      CSR_BLUE_MAX  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SHIFT_WIDTH-1:0]  shift;
      logic [MASK_WIDTH-1:0]   fmax;
      logic [SOURCE_WIDTH-1:0] divisor;   // never zero
   } chan_cfg_type;

endpackage

`default_nettype wire

### src/rtnp_cfg.sv
`default_nettype none

module rtnp_cfg
   import rtnp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output chan_cfg_type                    red_cfg,
   output chan_cfg_type                    green_cfg,
   output chan_cfg_type                    blue_cfg
);

   typedef struct packed {
      logic [SHIFT_WIDTH-1:0] shift;
      logic [MASK_WIDTH-1:0]  fmax;
   } field_type;

   // Lowest set bit, then the lowest run of ones; a zero mask gives zeros.
   function automatic field_type derive_field(logic [MASK_WIDTH-1:0] m);
      logic [MASK_WIDTH-1:0] low;
      logic [MASK_WIDTH:0]   sum;
      logic [MASK_WIDTH-1:0] run;
      logic [SHIFT_WIDTH-1:0] tz;
      field_type f;
      low = m & (~m + MASK_WIDTH'(1));
      sum = {1'b0, m} + {1'b0, low};
      run = m & ~sum[MASK_WIDTH-1:0];
      tz  = '0;
      for (int i = 0; i < MASK_WIDTH; i++) begin
         if (low[i]) begin
            tz = tz | SHIFT_WIDTH'(i);
         end
      end
      f.shift = tz;
      f.fmax  = run >> tz;
      return f;
   endfunction

   function automatic logic [SOURCE_WIDTH-1:0] fix_divisor(logic [SOURCE_WIDTH-1:0] d);
      return (d == '0) ? SOURCE_WIDTH'(1) : d;
   endfunction

   chan_cfg_type red_ff, red_in;
   chan_cfg_type green_ff, green_in;
   chan_cfg_type blue_ff, blue_in;
   field_type    wr_field;
   logic [SOURCE_WIDTH-1:0] wr_divisor;
   field_type    red_reset_field;
   field_type    green_reset_field;
   field_type    blue_reset_field;

   assign red_reset_field   = derive_field(RED_MASK_RESET);
   assign green_reset_field = derive_field(GREEN_MASK_RESET);
   assign blue_reset_field  = derive_field(BLUE_MASK_RESET);

   always_comb begin
      wr_field   = derive_field(csr_wdata[MASK_WIDTH-1:0]);
      wr_divisor = fix_divisor(csr_wdata[SOURCE_WIDTH-1:0]);
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RED_MASK: begin
               red_in.shift = wr_field.shift;
               red_in.fmax  = wr_field.fmax;
            end
            CSR_GREEN_MASK: begin
               green_in.shift = wr_field.shift;
               green_in.fmax  = wr_field.fmax;
            end
            CSR_BLUE_MASK: begin
               blue_in.shift = wr_field.shift;
               blue_in.fmax  = wr_field.fmax;
            end
            CSR_RED_MAX:   red_in.divisor   = wr_divisor;
            CSR_GREEN_MAX: green_in.divisor = wr_divisor;
            CSR_BLUE_MAX:  blue_in.divisor  = wr_divisor;
            default: ;   // drop writes to unknown registers
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '{shift: red_reset_field.shift,
                       fmax: red_reset_field.fmax,
                       divisor: SOURCE_MAX_RESET};
         green_ff <= '{shift: green_reset_field.shift,
                       fmax: green_reset_field.fmax,
                       divisor: SOURCE_MAX_RESET};
         blue_ff  <= '{shift: blue_reset_field.shift,
                       fmax: blue_reset_field.fmax,
                       divisor: SOURCE_MAX_RESET};
      end else begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red_cfg   = red_ff;
   assign green_cfg = green_ff;
   assign blue_cfg  = blue_ff;

endmodule

`default_nettype wire

### src/rtnp_div_step.sv
`default_nettype none

module rtnp_div_step
   import rtnp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic [SOURCE_WIDTH-1:0] divisor,
   input  wire logic [SOURCE_WIDTH-1:0] rem_i,
   input  wire logic [MASK_WIDTH-1:0]   work_i,
   input  wire logic                    sat_i,
   output logic      [SOURCE_WIDTH-1:0] rem_o,
   output logic      [MASK_WIDTH-1:0]   work_o,
   output logic                         sat_o
);

   logic [SOURCE_WIDTH-1:0] rem_ff, rem_in;
   logic [MASK_WIDTH-1:0]   work_ff, work_in;
   logic                    sat_ff;

   // Restoring division: shift dividend bits out of the top of work,
   // shift quotient bits in at the bottom.
   always_comb begin
      logic [SOURCE_WIDTH:0] trial;
      rem_in  = rem_i;
      work_in = work_i;
      for (int j = 0; j < DIV_STEP_BITS; j++) begin
         trial   = {rem_in, work_in[MASK_WIDTH-1]};
         work_in = {work_in[MASK_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in     = SOURCE_WIDTH'(trial - {1'b0, divisor});
            work_in[0] = 1'b1;
         end else begin
            rem_in = trial[SOURCE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         sat_ff  <= sat_i;
      end
   end

   assign rem_o  = rem_ff;
   assign work_o = work_ff;
   assign sat_o  = sat_ff;

endmodule

`default_nettype wire

### src/rtnp_channel.sv
`default_nettype none

module rtnp_channel
   import rtnp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [STAGES-2:0]       en,
   input  wire logic [SOURCE_WIDTH-1:0] value,
   input  chan_cfg_type                 cfg,
   output logic      [MASK_WIDTH-1:0]   field_out
);

   logic [PROD_WIDTH-1:0]   prod_in;
   logic [SOURCE_WIDTH-1:0] rem  [DIV_STAGES+1];
   logic [MASK_WIDTH-1:0]   work [DIV_STAGES+1];
   logic                    sat  [DIV_STAGES+1];
   logic [SOURCE_WIDTH-1:0] rem_ff;
   logic [MASK_WIDTH-1:0]   work_ff;
   logic                    sat_ff, sat_in;
   logic [MASK_WIDTH-1:0]   level;
   logic [MASK_WIDTH-1:0]   field_ff, field_in;

   // Input at or above the divisor always reaches the channel maximum, and
   // below it the quotient fits the mask width.
   assign prod_in = PROD_WIDTH'(value) * PROD_WIDTH'(cfg.fmax);
   assign sat_in  = (value >= cfg.divisor);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff  <= prod_in[PROD_WIDTH-1:MASK_WIDTH];
         work_ff <= prod_in[MASK_WIDTH-1:0];
         sat_ff  <= sat_in;
      end
   end

   assign rem[0]  = rem_ff;
   assign work[0] = work_ff;
   assign sat[0]  = sat_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      rtnp_div_step u_step (
         .clock   (clock),
         .en      (en[g+1]),
         .divisor (cfg.divisor),
         .rem_i   (rem[g]),
         .work_i  (work[g]),
         .sat_i   (sat[g]),
         .rem_o   (rem[g+1]),
         .work_o  (work[g+1]),
         .sat_o   (sat[g+1])
      );
   end

   assign level    = sat[DIV_STAGES] ? cfg.fmax : work[DIV_STAGES];
   assign field_in = level << cfg.shift;

   always_ff @(posedge clock) begin
      if (en[DIV_STAGES+1]) begin
         field_ff <= field_in;
      end
   end

   assign field_out = field_ff;

endmodule

`default_nettype wire

### src/rgb_to_native_pixel_pack.sv
// Each accepted item passes through 11 register stages (multiply, eight 4-bit divider
// steps, select/shift, pack); each divider step resolves four quotient bits.
// Throughput: one item per clock while the output is not stalled.
// A stalled output only backs up stages that are full; bubbles still take new items.
// Reset (synchronous, active high) empties the pipeline and loads the default
// 8-8-8 masks with source maxima of 255.
`default_nettype none

module rgb_to_native_pixel_pack
   import rtnp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [SOURCE_WIDTH-1:0]    req_red_in,
   input  wire logic [SOURCE_WIDTH-1:0]    req_green_in,
   input  wire logic [SOURCE_WIDTH-1:0]    req_blue_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [MASK_WIDTH-1:0]      rsp_pixel_out,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   chan_cfg_type red_cfg, green_cfg, blue_cfg;

   // Per-stage valid bits; a stage advances when it is empty or the next one advances.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   en;
   logic [MASK_WIDTH-1:0] red_field, green_field, blue_field;
   logic [MASK_WIDTH-1:0] pixel_ff, pixel_in;

   rtnp_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .red_cfg      (red_cfg),
      .green_cfg    (green_cfg),
      .blue_cfg     (blue_cfg)
   );

   always_comb begin
      en[STAGES] = rsp_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   rtnp_channel u_red (
      .clock     (clock),
      .en        (en[STAGES-2:0]),
      .value     (req_red_in),
      .cfg       (red_cfg),
      .field_out (red_field)
   );

   rtnp_channel u_green (
      .clock     (clock),
      .en        (en[STAGES-2:0]),
      .value     (req_green_in),
      .cfg       (green_cfg),
      .field_out (green_field)
   );

   rtnp_channel u_blue (
      .clock     (clock),
      .en        (en[STAGES-2:0]),
      .value     (req_blue_in),
      .cfg       (blue_cfg),
      .field_out (blue_field)
   );

   // Pack: overlapping masks simply OR, then trim to the pixel width.
   assign pixel_in = (red_field | green_field | blue_field) & PIXEL_KEEP;

   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         pixel_ff <= pixel_in;
      end
   end

   assign req_ready     = en[0];
   assign rsp_valid     = valid_ff[STAGES-1];
   assign rsp_pixel_out = pixel_ff;

   // An accepted item that does not leave in the same cycle adds one to the fill.
   a_fill_count : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready)) |=>
         ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("pipeline fill did not grow on accept");

   // A free output means every stage can move, so the input must be open.
   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output was taken");

   // A full pipeline with a stalled output takes nothing new.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_ready) |-> !req_ready)
      else $error("full pipeline accepted an item");

endmodule

`default_nettype wire
